>>> rtl/fixed_partition_fit_allocator_macros.svh
// Assertion helpers for the allocator RTL.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FPFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");
// Next-cycle implication.
`define FPFA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");
`else
`define FPFA_ASSERT_NOW(label, clk, rst, ante, cons)
`define FPFA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/fpfa_pkg.sv
package fpfa_pkg;

   localparam int PARTITIONS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_W      = $clog2(PARTITIONS);
   localparam int SCAN_W     = $clog2(PARTITIONS + 1);
   localparam int MODE_W     = 2;
   localparam int COUNT_W    = 5;
   localparam int CSR_W      = 5;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_ROUND = 2'd1;
   localparam logic [1:0] FUNC_ALLOC = 2'd2;

   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

   localparam logic CSR_ALLOC_MODE      = 1'b0;
   localparam logic CSR_PARTITION_COUNT = 1'b1;

   // one table entry presented to the compare unit
   typedef struct packed {
      logic                 valid;
      logic                 free;
      logic [IDX_W-1:0]     idx;
      logic [SIZE_BITS-1:0] size;
   } entry_type;

   // running candidate held by the compare unit
   typedef struct packed {
      logic                 have;
      logic                 fits;
      logic [IDX_W-1:0]     idx;
      logic [SIZE_BITS-1:0] size;
   } cand_type;

endpackage

>>> rtl/fpfa_ram.sv
module fpfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/fpfa_scan.sv
module fpfa_scan (
   input  logic                             clock,
   input  logic                             clear,
   input  logic [fpfa_pkg::MODE_W-1:0]      mode,
   input  logic [fpfa_pkg::SIZE_BITS-1:0]   need,
   input  fpfa_pkg::entry_type              entry,
   output fpfa_pkg::cand_type               cand
);

   logic                           have_ff, have_in;
   logic [fpfa_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [fpfa_pkg::SIZE_BITS-1:0] size_ff, size_in;
   logic                           fits;
   logic                           take;

   // compare of the entry against the request; the mode select compares against the held candidate
   assign fits = entry.size >= need;

   always_comb begin
      unique case (mode)
         fpfa_pkg::MODE_FIRST: take = fits && !have_ff;
         fpfa_pkg::MODE_BEST:  take = fits && (!have_ff || entry.size < size_ff);
         fpfa_pkg::MODE_WORST: take = !have_ff || entry.size > size_ff;
         default:              take = 1'b0;
      endcase
   end

   always_comb begin
      have_in = have_ff;
      idx_in  = idx_ff;
      size_in = size_ff;
      if (clear) begin
         have_in = 1'b0;
      end else if (entry.valid && entry.free && take) begin
         have_in = 1'b1;
         idx_in  = entry.idx;
         size_in = entry.size;
      end
   end

   always_ff @(posedge clock) begin
      have_ff <= have_in;
      idx_ff  <= idx_in;
      size_ff <= size_in;
   end

   assign cand.have = have_ff;
   assign cand.fits = size_ff >= need;
   assign cand.idx  = idx_ff;
   assign cand.size = size_ff;

endmodule

>>> rtl/fixed_partition_fit_allocator.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   func, partition_index, partition_size_in,
//                                            request_size, request_tag
// rsp_      out        rsp_valid/rsp_ready   granted, partition_id, granted_size, tag_out
// csr_      in         csr_we (no wait)      csr_index, csr_wdata
//
// Load and start-round requests go from accept to the finish state, which loads the output register.
// An allocation request steps through accept, one table read per partition through the size RAM
// and a single shared compare unit, a drain of the RAM latency when any partition is in use,
// then result.
// One request is in flight at a time; req_ready is high only while the sequencer is idle.
// A stalled result holds the sequencer in its finish state until rsp_ready.
// Reset is synchronous: all partitions free, mode first fit, partition count zero.
`include "fixed_partition_fit_allocator_macros.svh"

module fixed_partition_fit_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_partition_index,
   input  logic [15:0] req_partition_size_in,
   input  logic [15:0] req_request_size,
   input  logic [7:0]  req_request_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_granted,
   output logic [4:0]  rsp_partition_id,
   output logic [15:0] rsp_granted_size,
   output logic [7:0]  rsp_tag_out,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam int P  = fpfa_pkg::PARTITIONS;
   localparam int SB = fpfa_pkg::SIZE_BITS;
   localparam int IW = fpfa_pkg::IDX_W;
   localparam int SW = fpfa_pkg::SCAN_W;

   // configuration registers
   logic [fpfa_pkg::MODE_W-1:0]  mode_ff;
   logic [fpfa_pkg::COUNT_W-1:0] count_ff;

   // sequencer and latched request
   logic [1:0]    state_ff, state_in;
   logic [1:0]    func_ff, func_in;
   logic [15:0]   need16_ff, need16_in;
   logic [7:0]    tag_ff, tag_in;
   logic [SW-1:0] issue_ff, issue_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [P-1:0]  free_ff, free_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_granted_ff;
   logic [4:0]    rsp_id_ff;
   logic [15:0]   rsp_size_ff;
   logic [7:0]    rsp_tag_ff;

   logic          accept;
   logic          ram_we;
   logic          rd_en;
   logic          scan_clear;
   logic          out_load;
   logic          grant;
   logic [SW-1:0] used_cnt;
   logic [SB-1:0] need;
   logic [SB-1:0] rd_data;

   fpfa_pkg::entry_type entry;
   fpfa_pkg::cand_type  cand;

   assign accept    = req_valid && req_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign need      = SB'(need16_ff);

   // saturate the partition count to the table depth
   assign used_cnt = (int'(count_ff) > P) ? SW'(P) : SW'(count_ff);

   // drop loads aimed past the table
   assign ram_we = accept && req_func == fpfa_pkg::FUNC_LOAD && int'(req_partition_index) < P;

   fpfa_ram #(
      .WIDTH (SB),
      .DEPTH (P)
   ) u_size_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (IW'(req_partition_index)),
      .wdata (SB'(req_partition_size_in)),
      .re    (rd_en),
      .raddr (issue_ff[IW-1:0]),
      .rdata (rd_data)
   );

   assign entry.valid = rd_valid_ff;
   assign entry.free  = free_ff[rd_idx_ff];
   assign entry.idx   = rd_idx_ff;
   assign entry.size  = rd_data;

   fpfa_scan u_scan (
      .clock (clock),
      .clear (scan_clear),
      .mode  (mode_ff),
      .need  (need),
      .entry (entry),
      .cand  (cand)
   );

   // first and best fit only ever hold fitting entries; worst fit checks at the end
   assign grant = func_ff == fpfa_pkg::FUNC_ALLOC && cand.have && cand.fits;

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      need16_in   = need16_ff;
      tag_in      = tag_ff;
      issue_in    = issue_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      free_in     = free_ff;
      rd_en       = 1'b0;
      scan_clear  = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in    = req_func;
               need16_in  = req_request_size;
               tag_in     = req_request_tag;
               issue_in   = '0;
               scan_clear = 1'b1;
               if (req_func == fpfa_pkg::FUNC_ROUND) begin
                  free_in = '1;
               end
               state_in = (req_func == fpfa_pkg::FUNC_ALLOC) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            // issue one table read a cycle, then drain the RAM latency
            if (issue_ff < used_cnt) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_idx_in   = issue_ff[IW-1:0];
               issue_in    = issue_ff + SW'(1);
            end else if (!rd_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               if (grant) begin
                  free_in[cand.idx] = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= fpfa_pkg::MODE_FIRST;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               fpfa_pkg::CSR_ALLOC_MODE:      mode_ff  <= csr_wdata[fpfa_pkg::MODE_W-1:0];
               fpfa_pkg::CSR_PARTITION_COUNT: count_ff <= csr_wdata[fpfa_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      need16_ff <= need16_in;
      tag_ff    <= tag_in;
      issue_ff  <= issue_in;
      rd_idx_ff <= rd_idx_in;
      if (out_load) begin
         rsp_granted_ff <= grant;
         rsp_id_ff      <= grant ? (5'(cand.idx) + 5'd1) : 5'd0;
         rsp_size_ff    <= grant ? 16'(cand.size) : 16'd0;
         rsp_tag_ff     <= tag_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_partition_id = rsp_id_ff;
   assign rsp_granted_size = rsp_size_ff;
   assign rsp_tag_out      = rsp_tag_ff;

   `FPFA_ASSERT_NXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE)
   `FPFA_ASSERT_NXT(a_grant_marks_taken, clock, reset, out_load && grant, !free_ff[$past(cand.idx)])
   `FPFA_ASSERT_NOW(a_grant_fits, clock, reset, out_load && grant, cand.size >= need)
   `FPFA_ASSERT_NOW(a_read_in_range, clock, reset, rd_valid_ff, SW'(rd_idx_ff) < used_cnt)

endmodule
